[hw/rtl/ptve_pkg.sv]
// Shared types and constants of the triangle voice engine.
// Used by ptve_front, ptve_back and poly_triangle_voice_engine; no dependencies.
`default_nettype none

package ptve_pkg;

    localparam int unsigned ENV_W   = 25;
    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned VEL_W   = 16;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned SAMP_W  = 20;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NOTES   = 128;

    localparam logic [ENV_W-1:0] ENV_ONE       = 25'd16777216;
    localparam logic [ENV_W-1:0] ATTACK_RESET  = 25'd95109;
    localparam logic [ENV_W-1:0] RELEASE_RESET = 25'd2536;

    typedef enum logic [1:0] {
        OP_ON   = 2'd0,
        OP_OFF  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK  = 2'd0,
        REG_RELEASE = 2'd1,
        REG_SPARE0  = 2'd2,
        REG_SPARE1  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_SUSTAIN = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    typedef struct packed {
        t_op               op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_cmd;

    typedef struct packed {
        t_mode              mode;
        logic [NOTE_W-1:0]  note;
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [VEL_W-1:0]   level;
        logic [ENV_W-1:0]   env;
    } t_voice;

    localparam logic [31:0] OCTAVE_Q24 [12] = '{
        32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
        32'd172819773, 32'd183096171, 32'd193983636, 32'd205518503,
        32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
    };

endpackage

`default_nettype wire

[hw/rtl/ptve_front.sv]
// Command front end: two-entry queue of accepted commands, unused opcodes dropped.
// Depends on ptve_pkg.
`default_nettype none

module ptve_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output      logic          full,
    input  wire ptve_pkg::t_cmd i_cmd,
    output      logic          o_cmd_vld,
    output      ptve_pkg::t_cmd o_cmd,
    input  wire logic          i_cmd_take
);
    import ptve_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       wr, rd;

    assign full      = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        wr    = push && !full && (i_cmd.op != OP_NONE);
        rd    = i_cmd_take && o_cmd_vld;
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ptve_back.sv]
// Voice engine back end: voice memory, envelope sequencer, mixing pipeline, result register.
// Depends on ptve_pkg.
`default_nettype none

module ptve_back #(
    parameter int VOICES      = 16,
    parameter int SAMPLE_RATE = 44100
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_vld,
    input  wire ptve_pkg::t_cmd                 i_cmd,
    output      logic                           o_cmd_take,
    input  wire logic                           i_cfg_valid,
    input  wire logic [ptve_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ptve_pkg::ENV_W-1:0]     i_cfg_data,
    output      logic                           empty,
    input  wire logic                           pop,
    output      logic signed [ptve_pkg::SAMP_W-1:0] o_sample,
    output      logic [ptve_pkg::CNT_W-1:0]     o_voices_active
);
    import ptve_pkg::*;

    localparam int AW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCW   = $clog2(VOICES + 1);
    localparam int ACC_W = 22;
    localparam logic [AW-1:0] LAST = AW'(VOICES - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_RD    = 7'b0001000,
        S_EX    = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    logic [PHASE_W-1:0] step_rom [NOTES];

    for (genvar g = 0; g < NOTES; g++) begin : g_rom
        localparam logic [63:0] FREQ = 64'(OCTAVE_Q24[g % 12]) << (g / 12);
        localparam logic [63:0] STEP =
            (FREQ * 64'd256 + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        assign step_rom[g] = STEP[PHASE_W-1:0];
    end

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [AW-1:0]      r_idx, n_idx;
    logic [VOICES-1:0]  r_on;
    logic [ENV_W-1:0]   r_att, r_rel;
    t_voice             r_mem [VOICES];
    t_voice             r_rd;
    t_voice             n_rec, load_rec, wdata;
    logic               we, new_on, cur_on;
    logic [VCW-1:0]     r_vcnt;
    logic signed [ACC_W-1:0] r_acc;

    logic               r_a_vld, r_a_neg;
    logic [15:0]        r_a_mag;
    logic [ENV_W-1:0]   r_a_env;
    logic [VEL_W-1:0]   r_a_lvl;
    logic               r_b_vld, r_b_neg;
    logic [31:0]        r_b_prod;
    logic [ENV_W-1:0]   r_b_env;

    logic [ENV_W:0]     env_sum;
    logic [PHASE_W-1:0] ph_dist;
    logic [16:0]        dsh;
    logic               tri_neg;
    logic [15:0]        tri_mag;
    logic [56:0]        prod2;
    logic signed [ACC_W-1:0] term;

    logic               r_ovld;
    logic signed [SAMP_W-1:0] r_osamp;
    logic [CNT_W-1:0]   r_ocnt;

    assign empty           = !r_ovld;
    assign o_sample        = r_osamp;
    assign o_voices_active = r_ocnt;
    assign o_cmd_take      = (r_state == S_IDLE) && i_cmd_vld;

    always_comb begin
        cur_on = r_on[r_idx];
        n_rec  = r_rd;
        new_on = cur_on;
        env_sum = {1'b0, r_rd.env} + {1'b0, r_att};
        case (r_cmd.op)
            OP_OFF: begin
                if (cur_on && r_rd.note == r_cmd.note &&
                    (r_rd.mode == MODE_ATTACK || r_rd.mode == MODE_SUSTAIN)) begin
                    n_rec.mode = MODE_RELEASE;
                end
            end
            OP_TICK: begin
                if (cur_on) begin
                    case (r_rd.mode)
                        MODE_ATTACK: begin
                            if (env_sum >= {1'b0, ENV_ONE}) begin
                                n_rec.env  = ENV_ONE;
                                n_rec.mode = MODE_SUSTAIN;
                            end else begin
                                n_rec.env = env_sum[ENV_W-1:0];
                            end
                        end
                        MODE_RELEASE: begin
                            if (r_rd.env <= r_rel) begin
                                n_rec.env  = '0;
                                n_rec.mode = MODE_OFF;
                                new_on     = 1'b0;
                            end else begin
                                n_rec.env = r_rd.env - r_rel;
                            end
                        end
                        default: ;
                    endcase
                    n_rec.phase = r_rd.phase + r_rd.step;
                end
            end
            default: ;
        endcase

        ph_dist = r_rd.phase[PHASE_W-1] ? {1'b0, r_rd.phase[PHASE_W-2:0]}
                                        : (32'h8000_0000 - r_rd.phase);
        dsh     = ph_dist[31:15];
        tri_neg = !dsh[16] && !dsh[15];
        tri_mag = tri_neg ? 16'(17'd32768 - dsh) : 16'(dsh - 17'd32768);

        load_rec.mode  = MODE_ATTACK;
        load_rec.note  = r_cmd.note;
        load_rec.phase = '0;
        load_rec.step  = step_rom[r_cmd.note];
        load_rec.level = r_cmd.vel;
        load_rec.env   = '0;

        we    = (r_state == S_EX) || (r_state == S_LOAD);
        wdata = (r_state == S_LOAD) ? load_rec : n_rec;

        prod2 = r_b_prod * r_b_env;
        term  = r_b_neg ? -ACC_W'($signed({1'b0, prod2[56:41]}))
                        :  ACC_W'($signed({1'b0, prod2[56:41]}));
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_cmd_vld) begin
                    n_state = (i_cmd.op == OP_ON) ? S_SCAN : S_RD;
                end
            end
            S_SCAN: begin
                if (!cur_on) begin
                    n_state = S_LOAD;
                end else if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOAD: n_state = S_IDLE;
            S_RD:   n_state = S_EX;
            S_EX: begin
                if (r_idx == LAST) begin
                    n_state = (r_cmd.op == OP_TICK) ? S_DRAIN : S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DRAIN: begin
                if (!r_a_vld && !r_b_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_on    <= '0;
            r_att   <= ATTACK_RESET;
            r_rel   <= RELEASE_RESET;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_ovld  <= 1'b0;
            r_vcnt  <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_ATTACK:  r_att <= i_cfg_data;
                    REG_RELEASE: r_rel <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_LOAD) begin
                r_on[r_idx] <= 1'b1;
            end else if (r_state == S_EX) begin
                r_on[r_idx] <= new_on;
            end
            r_a_vld <= (r_state == S_EX) && (r_cmd.op == OP_TICK) && cur_on;
            r_b_vld <= r_a_vld;
            if (r_state == S_IDLE) begin
                r_acc  <= '0;
                r_vcnt <= '0;
            end else begin
                if (r_b_vld) begin
                    r_acc <= r_acc + term;
                end
                if (r_state == S_EX && r_cmd.op == OP_TICK && new_on) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end
            if (r_state == S_DONE && !r_ovld) begin
                r_ovld <= 1'b1;
            end else if (pop && r_ovld) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        r_rd <= r_mem[r_idx];
        if (we) begin
            r_mem[r_idx] <= wdata;
        end
        r_a_neg  <= tri_neg;
        r_a_mag  <= tri_mag;
        r_a_env  <= n_rec.env;
        r_a_lvl  <= r_rd.level;
        r_b_neg  <= r_a_neg;
        r_b_prod <= r_a_mag * r_a_lvl;
        r_b_env  <= r_a_env;
        if (r_state == S_DONE && !r_ovld) begin
            if (r_acc > ACC_W'(524287)) begin
                r_osamp <= 20'sd524287;
            end else if (r_acc < -ACC_W'(524288)) begin
                r_osamp <= -20'sd524288;
            end else begin
                r_osamp <= r_acc[SAMP_W-1:0];
            end
            r_ocnt <= (r_vcnt > VCW'(31)) ? 5'd31 : CNT_W'(r_vcnt);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/poly_triangle_voice_engine.sv]
// Polyphonic triangle voice engine top level: command queue front, voice engine back.
// Depends on ptve_pkg, ptve_front, ptve_back.
// Note-on: free-voice scan, one voice a cycle, then a load of the chosen voice. Note-off:
// each voice is read and updated in turn. Tick: each voice is read and updated in turn, then a
// two-stage multiply drain. One item at a time in the back; two more wait in the front queue.
// Reset (synchronous, active low) turns all voices off and restores both envelope steps.
`default_nettype none

module poly_triangle_voice_engine #(
    parameter int VOICES      = 16,
    parameter int SAMPLE_RATE = 44100
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output      logic                                full,
    input  wire logic [1:0]                          i_opcode,
    input  wire logic [ptve_pkg::NOTE_W-1:0]         i_note,
    input  wire logic [ptve_pkg::VEL_W-1:0]          i_velocity,
    output      logic                                empty,
    input  wire logic                                pop,
    output      logic signed [ptve_pkg::SAMP_W-1:0]  o_sample,
    output      logic [ptve_pkg::CNT_W-1:0]          o_voices_active,
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [ptve_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ptve_pkg::ENV_W-1:0]          i_cfg_data
);
    import ptve_pkg::*;

    t_cmd in_cmd, q_cmd;
    logic q_vld, q_take;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_cmd.op   = t_op'(i_opcode);
        in_cmd.note = i_note;
        in_cmd.vel  = i_velocity;
    end

    ptve_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (in_cmd),
        .o_cmd_vld  (q_vld),
        .o_cmd      (q_cmd),
        .i_cmd_take (q_take)
    );

    ptve_back #(
        .VOICES      (VOICES),
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_vld       (q_vld),
        .i_cmd           (q_cmd),
        .o_cmd_take      (q_take),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .empty           (empty),
        .pop             (pop),
        .o_sample        (o_sample),
        .o_voices_active (o_voices_active)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench of poly_triangle_voice_engine: directed and random note and tick items,
// a local voice predictor, random idling and stalls on both queues, and envelope step writes.
// Depends on ptve_pkg and the poly_triangle_voice_engine RTL.
`timescale 1ns / 100ps

module tb_top;
    import ptve_pkg::*;

    localparam int NUM_VOICES = 16;
    localparam int RATE_HZ    = 44100;
    localparam int CYCLE_CAP  = 1500000;
    localparam int SETTLE     = 200;

    typedef struct {
        logic signed [SAMP_W-1:0] sample;
        logic [CNT_W-1:0]         count;
    } t_mix;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        push;
    logic                        full;
    logic [1:0]                  i_opcode;
    logic [NOTE_W-1:0]           i_note;
    logic [VEL_W-1:0]            i_velocity;
    logic                        empty;
    logic                        pop;
    logic signed [SAMP_W-1:0]    o_sample;
    logic [CNT_W-1:0]            o_voices_active;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [ENV_W-1:0]            i_cfg_data;

    poly_triangle_voice_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_note          (i_note),
        .i_velocity      (i_velocity),
        .empty           (empty),
        .pop             (pop),
        .o_sample        (o_sample),
        .o_voices_active (o_voices_active),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor state
    logic [31:0]       rise_step;
    logic [31:0]       fall_step;
    t_mode             v_mode  [NUM_VOICES];
    logic [31:0]       v_phase [NUM_VOICES];
    logic [31:0]       v_inc   [NUM_VOICES];
    logic [15:0]       v_level [NUM_VOICES];
    logic [31:0]       v_env   [NUM_VOICES];
    logic [7:0]        v_note  [NUM_VOICES];

    t_mix              mix_q[$];
    logic [NOTE_W-1:0] held_notes[$];
    int                errors;
    int                cycles;
    int                hold_cnt;
    bit                calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("poly_triangle_voice_engine: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] note_inc(logic [NOTE_W-1:0] n);
        logic [63:0] f;
        f = 64'(OCTAVE_Q24[n % 12]) << (n / 12);
        return 32'((f * 64'd256 + 64'(RATE_HZ / 2)) / 64'(RATE_HZ));
    endfunction

    task automatic reset_voices();
        rise_step = 32'(ATTACK_RESET);
        fall_step = 32'(RELEASE_RESET);
        for (int i = 0; i < NUM_VOICES; i++) begin
            v_mode[i]  = MODE_OFF;
            v_phase[i] = '0;
            v_inc[i]   = '0;
            v_level[i] = '0;
            v_env[i]   = '0;
            v_note[i]  = 8'd255;
        end
    endtask

    task automatic apply_item(t_op op, logic [NOTE_W-1:0] n, logic [VEL_W-1:0] vel);
        int          slot;
        longint      acc;
        int          live;
        logic [31:0] d;
        longint      tri_v;
        logic [63:0] mag;
        t_mix        m;
        slot = 0;
        acc  = 0;
        live = 0;
        case (op)
            OP_ON: begin
                for (int i = NUM_VOICES - 1; i >= 0; i--)
                    if (v_mode[i] == MODE_OFF) slot = i;
                v_note[slot]  = 8'(n);
                v_inc[slot]   = note_inc(n);
                v_level[slot] = vel;
                v_env[slot]   = '0;
                v_phase[slot] = '0;
                v_mode[slot]  = MODE_ATTACK;
            end
            OP_OFF: begin
                for (int i = 0; i < NUM_VOICES; i++)
                    if (v_note[i] == 8'(n) &&
                        (v_mode[i] == MODE_ATTACK || v_mode[i] == MODE_SUSTAIN))
                        v_mode[i] = MODE_RELEASE;
            end
            OP_TICK: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (v_mode[i] == MODE_OFF) continue;
                    if (v_mode[i] == MODE_ATTACK) begin
                        v_env[i] = v_env[i] + rise_step;
                        if (v_env[i] >= 32'(ENV_ONE)) begin
                            v_env[i]  = 32'(ENV_ONE);
                            v_mode[i] = MODE_SUSTAIN;
                        end
                    end else if (v_mode[i] == MODE_RELEASE) begin
                        if (v_env[i] <= fall_step) begin
                            v_env[i]  = '0;
                            v_mode[i] = MODE_OFF;
                        end else begin
                            v_env[i] = v_env[i] - fall_step;
                        end
                    end
                    d     = v_phase[i] >= 32'h8000_0000 ? v_phase[i] - 32'h8000_0000
                                                         : 32'h8000_0000 - v_phase[i];
                    tri_v = longint'(d >> 15) - 32768;
                    mag   = 64'(tri_v < 0 ? -tri_v : tri_v);
                    mag   = (mag * 64'(v_env[i]) * 64'(v_level[i])) >> 41;
                    acc  += (tri_v < 0) ? -longint'(mag) : longint'(mag);
                    v_phase[i] = v_phase[i] + v_inc[i];
                    if (v_mode[i] != MODE_OFF) live++;
                end
                if (acc > 524287) acc = 524287;
                if (acc < -524288) acc = -524288;
                if (live > 31) live = 31;
                m.sample = SAMP_W'(acc);
                m.count  = CNT_W'(live);
                mix_q.push_back(m);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("ERROR %0s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (mix_q.size() == 0) begin
                report("unexpected item", o_sample, 0);
            end else begin
                if (o_sample !== mix_q[0].sample)
                    report("sample", o_sample, mix_q[0].sample);
                if (o_voices_active !== mix_q[0].count)
                    report("voices_active", o_voices_active, mix_q[0].count);
                void'(mix_q.pop_front());
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            pop      <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 26);
        end
    end

    task automatic send_item(t_op op, logic [NOTE_W-1:0] n, logic [VEL_W-1:0] vel);
        while (!calm && $urandom_range(99) < 26) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_opcode   <= op;
        i_note     <= n;
        i_velocity <= vel;
        do @(posedge i_clk); while (full);
        apply_item(op, n, vel);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (mix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [ENV_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ATTACK) rise_step = 32'(val);
        else if (idx == REG_RELEASE) fall_step = 32'(val);
        @(posedge i_clk);
    endtask

    task automatic send_ticks(int count);
        for (int i = 0; i < count; i++)
            send_item(OP_TICK, NOTE_W'($urandom), VEL_W'($urandom));
    endtask

    task automatic test_reset_steps();
        send_item(OP_ON, 7'd69, 16'hFFFF);
        send_item(OP_ON, 7'd0, 16'h0000);
        send_item(OP_ON, 7'd127, 16'h8001);
        send_ticks(6);
        send_item(OP_OFF, 7'd69, 16'h0);
        send_item(OP_NONE, 7'd5, 16'h1234);
        send_ticks(3);
        drain();
    endtask

    task automatic test_envelope_extremes();
        write_reg(REG_ATTACK, 25'd16777216);
        write_reg(REG_RELEASE, 25'd16777216);
        write_reg(REG_SPARE0, 25'h1FFFFFF);
        write_reg(REG_SPARE1, 25'h0AAAAAA);
        send_item(OP_ON, 7'd127, 16'hFFFF);
        send_item(OP_ON, 7'd60, 16'hFFFF);
        send_ticks(2);
        send_item(OP_OFF, 7'd127, 16'h0);
        send_item(OP_OFF, 7'd60, 16'h0);
        send_ticks(2);
        drain();
        write_reg(REG_ATTACK, 25'h1FFFFFF);
        write_reg(REG_RELEASE, 25'd0);
        send_item(OP_ON, 7'd33, 16'h7FFF);
        send_ticks(2);
        send_item(OP_OFF, 7'd33, 16'h0);
        send_ticks(3);
        drain();
        write_reg(REG_ATTACK, 25'd0);
        write_reg(REG_RELEASE, 25'h1FFFFFF);
        send_item(OP_ON, 7'd90, 16'hFFFF);
        send_ticks(2);
        send_item(OP_OFF, 7'd90, 16'h0);
        send_ticks(2);
        drain();
        write_reg(REG_ATTACK, 25'd1);
        write_reg(REG_RELEASE, 25'd1);
        send_item(OP_ON, 7'd45, 16'hFFFF);
        send_ticks(3);
        send_item(OP_OFF, 7'd45, 16'h0);
        send_ticks(2);
        drain();
    endtask

    task automatic test_voice_steal();
        write_reg(REG_ATTACK, 25'd4000000);
        write_reg(REG_RELEASE, 25'd3000000);
        for (int i = 0; i < NUM_VOICES + 2; i++)
            send_item(OP_ON, 7'(20 + 5 * i), 16'(16'hFFFF - i * 997));
        send_ticks(8);
        send_item(OP_OFF, 7'd20, 16'h0);
        send_item(OP_OFF, 7'd25, 16'h0);
        send_ticks(8);
        drain();
    endtask

    task automatic test_backpressure();
        hold_cnt <= 500;
        send_ticks(30);
        drain();
    endtask

    task automatic random_phase(int count);
        int                pick;
        int                at;
        logic [NOTE_W-1:0] n;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                n = NOTE_W'($urandom);
                held_notes.push_back(n);
                send_item(OP_ON, n, VEL_W'($urandom));
            end else if (pick < 40) begin
                if (held_notes.size() != 0 && $urandom_range(9) != 0) begin
                    at = $urandom_range(held_notes.size() - 1);
                    n  = held_notes[at];
                    held_notes.delete(at);
                end else begin
                    n = NOTE_W'($urandom);
                end
                send_item(OP_OFF, n, VEL_W'($urandom));
            end else if (pick < 96) begin
                send_item(OP_TICK, NOTE_W'($urandom), VEL_W'($urandom));
            end else begin
                send_item(OP_NONE, NOTE_W'($urandom), VEL_W'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_random();
        for (int p = 0; p < 5; p++) begin
            calm = (p == 2);
            write_reg(REG_ATTACK, 25'($urandom_range(16777216, 50000)));
            write_reg(REG_RELEASE, 25'($urandom_range(4000000, 200000)));
            random_phase(160);
        end
        calm = 1'b0;
    endtask

    initial begin
        errors      = 0;
        cycles      = 0;
        hold_cnt    = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_opcode    = OP_NONE;
        i_note      = '0;
        i_velocity  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ATTACK;
        i_cfg_data  = '0;
        reset_voices();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        test_reset_steps();
        test_envelope_extremes();
        test_voice_steal();
        test_backpressure();
        test_random();

        if (errors == 0)
            $display("poly_triangle_voice_engine: match");
        else
            $display("poly_triangle_voice_engine: mismatch");
        $finish;
    end

endmodule
